@@ src/drt_pkg.sv @@
package drt_pkg;

  // Store geometry
  localparam int MAX_RECTS = 8;
  localparam int IDX_W     = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int CNT_W     = $clog2(MAX_RECTS + 1);

  // Pixel and fixed-point widths
  localparam int PIX_W = 15;
  localparam int FIX_W = 21;
  localparam int CFG_INDEX_W = 2;

  // Register reset values
  localparam logic [PIX_W-1:0] SURF_W_RESET = 15'd1920;
  localparam logic [PIX_W-1:0] SURF_H_RESET = 15'd1080;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_SURF_W = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SURF_H = 2'd1;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_MARK  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_EMPTY   = 3'd0,
    ST_COVERED = 3'd1,
    ST_STORED  = 3'd2,
    ST_MERGED  = 3'd3,
    ST_OTHER   = 3'd4
  } status_e;

  typedef struct packed {
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] width;
    logic [PIX_W-1:0] height;
  } rect_t;

endpackage

@@ src/dirty_rectangle_tracker_core.sv @@
// Dirty rectangle tracker. Holds up to drt_pkg::MAX_RECTS damaged rectangles
// in pixels. An add word (opcode 0) carries a signed Q16.4 rectangle; its
// left/top edges are floored and clamped at 0, its right/bottom edges
// (origin plus extent) are ceiled and clamped at the surface size set by
// register 0 (width) and register 1 (height). Empty or already covered
// rectangles are dropped, others are appended; on overflow the whole store
// collapses into one bounding box. Opcode 1 marks the whole surface, opcode
// 2 empties the store, opcode 3 is ignored. After every input word the held
// rectangles go out as a run of words, last_o on the final one; an empty
// store gives one word with region_valid_o low. Timing: one item at a time,
// in_stall_o stays high until its run has been handed to the output
// register. An add word passes through acceptance, edge rounding and
// clamping, the empty check, the containment scan (skipped for an empty
// rectangle, one stored rectangle per cycle through a single compare
// unit, ending early on a cover) and then emission of the run; mark,
// clear and ignored words go straight from acceptance to emission.
// Output stalls stretch the emission phase. A new word is taken while
// the final result still sits in the output register. Config writes are
// always ready and should only be issued while the block is idle.
module dirty_rectangle_tracker_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       opcode_i,
  input  logic signed [drt_pkg::FIX_W-1:0] rect_left_i,
  input  logic signed [drt_pkg::FIX_W-1:0] rect_top_i,
  input  logic signed [drt_pkg::FIX_W-1:0] rect_width_i,
  input  logic signed [drt_pkg::FIX_W-1:0] rect_height_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [2:0]                       status_o,
  output logic [3:0]                       held_count_o,
  output logic                             region_valid_o,
  output logic [drt_pkg::PIX_W-1:0]        region_left_o,
  output logic [drt_pkg::PIX_W-1:0]        region_top_o,
  output logic [drt_pkg::PIX_W-1:0]        region_width_o,
  output logic [drt_pkg::PIX_W-1:0]        region_height_o,
  output logic                             last_o,
  // config write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [drt_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [drt_pkg::PIX_W-1:0]        cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EDGE,
    S_CHECK,
    S_SCAN,
    S_EMIT
  } state_e;

  state_e state_q;

  // config registers
  logic [drt_pkg::PIX_W-1:0] surf_w_q, surf_h_q;

  // store and fill count
  drt_pkg::rect_t            store_q [drt_pkg::MAX_RECTS];
  logic [drt_pkg::CNT_W-1:0] count_q;
  logic [drt_pkg::CNT_W-1:0] idx_q;

  // captured input word
  logic signed [drt_pkg::FIX_W-1:0] x_q, y_q, w_q, h_q;

  // clamped edges: left/top are non-negative, right/bottom signed
  logic [15:0]        l_q, t_q;
  logic signed [18:0] r_q, b_q;

  // bounding box accumulated during the scan
  logic [drt_pkg::PIX_W-1:0] bl_q, bt_q;
  logic [15:0]               br_q, bb_q;

  logic [2:0] status_q;

  // output register
  logic                      ov_q;
  logic [2:0]                o_status_q;
  logic [3:0]                o_count_q;
  logic                      o_rvalid_q;
  drt_pkg::rect_t            o_rect_q;
  logic                      o_last_q;

  logic in_accept;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------
  // Edge rounding: floor of origin, ceil of origin plus extent
  // ---------------------------------------------------------------------
  logic signed [22:0] xr_sum, yb_sum;
  logic signed [18:0] ce_x, ce_y;
  logic signed [18:0] sw_s, sh_s;
  logic signed [16:0] fl_x, fl_y;

  always_comb begin
    xr_sum = 23'(x_q) + 23'(w_q) + 23'sd15;
    yb_sum = 23'(y_q) + 23'(h_q) + 23'sd15;
    ce_x   = xr_sum[22:4];
    ce_y   = yb_sum[22:4];
    fl_x   = x_q[drt_pkg::FIX_W-1:4];
    fl_y   = y_q[drt_pkg::FIX_W-1:4];
    sw_s   = $signed({4'b0, surf_w_q});
    sh_s   = $signed({4'b0, surf_h_q});
  end

  // ---------------------------------------------------------------------
  // Shared compare unit: one held rectangle against the new one
  // ---------------------------------------------------------------------
  drt_pkg::rect_t            hold;
  logic [15:0]               hold_r, hold_b;
  logic [drt_pkg::PIX_W-1:0] n_left, n_top;
  logic [15:0]               n_right, n_bot;
  logic                      covered, scan_done, is_empty, has_room;

  always_comb begin
    hold      = store_q[idx_q[drt_pkg::IDX_W-1:0]];
    hold_r    = {1'b0, hold.left} + {1'b0, hold.width};
    hold_b    = {1'b0, hold.top} + {1'b0, hold.height};
    // only meaningful once the empty check has passed
    n_left    = l_q[drt_pkg::PIX_W-1:0];
    n_top     = t_q[drt_pkg::PIX_W-1:0];
    n_right   = r_q[15:0];
    n_bot     = b_q[15:0];
    covered   = (n_left >= hold.left) && (n_top >= hold.top) &&
                (n_right <= hold_r) && (n_bot <= hold_b);
    scan_done = (idx_q == count_q);
    is_empty  = (r_q <= $signed({3'b0, l_q})) || (b_q <= $signed({3'b0, t_q}));
    has_room  = (count_q < drt_pkg::CNT_W'(drt_pkg::MAX_RECTS));
  end

  // ---------------------------------------------------------------------
  // Store write port
  // ---------------------------------------------------------------------
  logic                      wr_en;
  logic [drt_pkg::IDX_W-1:0] wr_idx;
  drt_pkg::rect_t            wr_rect;

  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = '0;
    wr_rect = '{left: '0, top: '0, width: surf_w_q, height: surf_h_q};
    if (state_q == S_IDLE) begin
      wr_en = in_accept && (opcode_i == drt_pkg::OP_MARK);
    end else if (state_q == S_SCAN && scan_done) begin
      wr_en = 1'b1;
      if (has_room) begin
        wr_idx  = count_q[drt_pkg::IDX_W-1:0];
        wr_rect = '{left: n_left, top: n_top,
                    width: drt_pkg::PIX_W'(n_right - {1'b0, n_left}),
                    height: drt_pkg::PIX_W'(n_bot - {1'b0, n_top})};
      end else begin
        wr_rect = '{left: bl_q, top: bt_q,
                    width: drt_pkg::PIX_W'(br_q - {1'b0, bl_q}),
                    height: drt_pkg::PIX_W'(bb_q - {1'b0, bt_q})};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_idx] <= wr_rect;
    end
  end

  // ---------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      surf_w_q <= drt_pkg::SURF_W_RESET;
      surf_h_q <= drt_pkg::SURF_H_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == drt_pkg::CFG_SURF_W) begin
        surf_w_q <= cfg_data_i;
      end else if (cfg_index_i == drt_pkg::CFG_SURF_H) begin
        surf_h_q <= cfg_data_i;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer and output register
  // ---------------------------------------------------------------------
  logic out_free;
  assign out_free = !ov_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      idx_q      <= '0;
      ov_q       <= 1'b0;
      x_q        <= '0;
      y_q        <= '0;
      w_q        <= '0;
      h_q        <= '0;
      l_q        <= '0;
      t_q        <= '0;
      r_q        <= '0;
      b_q        <= '0;
      bl_q       <= '0;
      bt_q       <= '0;
      br_q       <= '0;
      bb_q       <= '0;
      status_q   <= drt_pkg::ST_OTHER;
      o_status_q <= drt_pkg::ST_EMPTY;
      o_count_q  <= '0;
      o_rvalid_q <= 1'b0;
      o_rect_q   <= '0;
      o_last_q   <= 1'b0;
    end else begin
      // output word loads in the emit state, otherwise drains when taken
      if (state_q == S_EMIT && out_free) begin
        ov_q <= 1'b1;
      end else if (ov_q && !out_stall_i) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            x_q      <= rect_left_i;
            y_q      <= rect_top_i;
            w_q      <= rect_width_i;
            h_q      <= rect_height_i;
            idx_q    <= '0;
            status_q <= drt_pkg::ST_OTHER;
            unique case (opcode_i)
              drt_pkg::OP_ADD:   state_q <= S_EDGE;
              drt_pkg::OP_MARK: begin
                count_q <= drt_pkg::CNT_W'(1);
                state_q <= S_EMIT;
              end
              drt_pkg::OP_CLEAR: begin
                count_q <= '0;
                state_q <= S_EMIT;
              end
              default:           state_q <= S_EMIT;
            endcase
          end
        end
        S_EDGE: begin
          l_q     <= fl_x[16] ? 16'd0 : fl_x[15:0];
          t_q     <= fl_y[16] ? 16'd0 : fl_y[15:0];
          r_q     <= (ce_x > sw_s) ? sw_s : ce_x;
          b_q     <= (ce_y > sh_s) ? sh_s : ce_y;
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          idx_q <= '0;
          if (is_empty) begin
            status_q <= drt_pkg::ST_EMPTY;
            state_q  <= S_EMIT;
          end else begin
            bl_q    <= n_left;
            bt_q    <= n_top;
            br_q    <= n_right;
            bb_q    <= n_bot;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            idx_q <= '0;
            if (has_room) begin
              count_q  <= count_q + drt_pkg::CNT_W'(1);
              status_q <= drt_pkg::ST_STORED;
            end else begin
              count_q  <= drt_pkg::CNT_W'(1);
              status_q <= drt_pkg::ST_MERGED;
            end
            state_q <= S_EMIT;
          end else if (covered) begin
            idx_q    <= '0;
            status_q <= drt_pkg::ST_COVERED;
            state_q  <= S_EMIT;
          end else begin
            if (hold.left < bl_q) bl_q <= hold.left;
            if (hold.top < bt_q)  bt_q <= hold.top;
            if (hold_r > br_q)    br_q <= hold_r;
            if (hold_b > bb_q)    bb_q <= hold_b;
            idx_q <= idx_q + drt_pkg::CNT_W'(1);
          end
        end
        S_EMIT: begin
          if (out_free) begin
            o_status_q <= status_q;
            o_count_q  <= 4'(count_q);
            if (count_q == '0) begin
              o_rvalid_q <= 1'b0;
              o_rect_q   <= '0;
              o_last_q   <= 1'b1;
              state_q    <= S_IDLE;
            end else begin
              o_rvalid_q <= 1'b1;
              o_rect_q   <= hold;
              o_last_q   <= (idx_q + drt_pkg::CNT_W'(1) == count_q);
              idx_q      <= idx_q + drt_pkg::CNT_W'(1);
              if (idx_q + drt_pkg::CNT_W'(1) == count_q) begin
                state_q <= S_IDLE;
              end
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = ov_q;
  assign status_o        = o_status_q;
  assign held_count_o    = o_count_q;
  assign region_valid_o  = o_rvalid_q;
  assign region_left_o   = o_rect_q.left;
  assign region_top_o    = o_rect_q.top;
  assign region_width_o  = o_rect_q.width;
  assign region_height_o = o_rect_q.height;
  assign last_o          = o_last_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= drt_pkg::CNT_W'(drt_pkg::MAX_RECTS))
    else $error("fill count above store depth");

  a_scan_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN || state_q == S_EMIT) |-> idx_q <= count_q)
    else $error("walk index past fill count");

  a_empty_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !region_valid_o) |-> (held_count_o == 4'd0 && last_o))
    else $error("empty-store word without zero count and last");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("input not stalled while item in work");

endmodule

@@ tb/dirty_rectangle_tracker_checker.sv @@
`timescale 1ns / 1ps

// Watches the three channels of the tracker, keeps its own copy of the
// damage store and the surface size, and checks every result word.
module dirty_rectangle_tracker_checker
  import drt_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic [1:0]              opcode_i,
  input  logic signed [FIX_W-1:0] rect_left_i,
  input  logic signed [FIX_W-1:0] rect_top_i,
  input  logic signed [FIX_W-1:0] rect_width_i,
  input  logic signed [FIX_W-1:0] rect_height_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic [2:0]              status_i,
  input  logic [3:0]              held_count_i,
  input  logic                    region_valid_i,
  input  logic [PIX_W-1:0]        region_left_i,
  input  logic [PIX_W-1:0]        region_top_i,
  input  logic [PIX_W-1:0]        region_width_i,
  input  logic [PIX_W-1:0]        region_height_i,
  input  logic                    last_i,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [PIX_W-1:0]        cfg_data_i,
  output int                      mismatch_count_o,
  output int                      pending_words_o
);

  typedef struct packed {
    logic [2:0]       status;
    logic [3:0]       held;
    logic             region_valid;
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] width;
    logic [PIX_W-1:0] height;
    logic             last;
  } region_word_t;

  region_word_t region_q[$];
  region_word_t want;

  // Damage store kept as pixel edges
  int dmg_l[MAX_RECTS];
  int dmg_t[MAX_RECTS];
  int dmg_r[MAX_RECTS];
  int dmg_b[MAX_RECTS];
  int dmg_count;
  logic [PIX_W-1:0] surf_w;
  logic [PIX_W-1:0] surf_h;
  int mismatches = 0;

  function automatic int floor_px(int v);
    return v >>> 4;
  endfunction

  function automatic int ceil_px(int v);
    return -((-v) >>> 4);
  endfunction

  function automatic status_e add_damage(int x, int y, int w, int h);
    int l, t, r, b;
    l = floor_px(x);
    t = floor_px(y);
    r = ceil_px(x + w);
    b = ceil_px(y + h);
    if (l < 0) l = 0;
    if (t < 0) t = 0;
    if (r > int'(surf_w)) r = int'(surf_w);
    if (b > int'(surf_h)) b = int'(surf_h);
    if (r <= l || b <= t) return ST_EMPTY;
    for (int i = 0; i < dmg_count; i++) begin
      if (l >= dmg_l[i] && t >= dmg_t[i] && r <= dmg_r[i] && b <= dmg_b[i])
        return ST_COVERED;
    end
    if (dmg_count < MAX_RECTS) begin
      dmg_l[dmg_count] = l;
      dmg_t[dmg_count] = t;
      dmg_r[dmg_count] = r;
      dmg_b[dmg_count] = b;
      dmg_count++;
      return ST_STORED;
    end
    // overflow: everything collapses into one bounding box
    for (int i = 0; i < dmg_count; i++) begin
      if (dmg_l[i] < l) l = dmg_l[i];
      if (dmg_t[i] < t) t = dmg_t[i];
      if (dmg_r[i] > r) r = dmg_r[i];
      if (dmg_b[i] > b) b = dmg_b[i];
    end
    dmg_l[0] = l;
    dmg_t[0] = t;
    dmg_r[0] = r;
    dmg_b[0] = b;
    dmg_count = 1;
    return ST_MERGED;
  endfunction

  function automatic void predict_damage_run(logic [1:0] op, int x, int y, int w, int h);
    status_e st;
    region_word_t exp_word;
    st = ST_OTHER;
    case (op)
      OP_ADD: st = add_damage(x, y, w, h);
      OP_MARK: begin
        dmg_l[0] = 0;
        dmg_t[0] = 0;
        dmg_r[0] = int'(surf_w);
        dmg_b[0] = int'(surf_h);
        dmg_count = 1;
      end
      OP_CLEAR: dmg_count = 0;
      default: ;
    endcase
    if (dmg_count == 0) begin
      exp_word = '{st, 4'd0, 1'b0, '0, '0, '0, '0, 1'b1};
      region_q.insert(region_q.size(), exp_word);
    end else begin
      for (int i = 0; i < dmg_count; i++) begin
        exp_word = '{st, 4'(dmg_count), 1'b1,
                     PIX_W'(dmg_l[i]), PIX_W'(dmg_t[i]),
                     PIX_W'(dmg_r[i] - dmg_l[i]), PIX_W'(dmg_b[i] - dmg_t[i]),
                     (i == dmg_count - 1)};
        region_q.insert(region_q.size(), exp_word);
      end
    end
  endfunction

  function automatic void check_field(string name, int want_v, int got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      surf_w    = SURF_W_RESET;
      surf_h    = SURF_H_RESET;
      dmg_count = 0;
      region_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SURF_W: surf_w = cfg_data_i;
          CFG_SURF_H: surf_h = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        predict_damage_run(opcode_i, rect_left_i, rect_top_i, rect_width_i, rect_height_i);
      if (out_valid_i && !out_stall_i) begin
        if (region_q.size() == 0) begin
          $error("result word with no expectation pending");
          mismatches++;
        end else begin
          want = region_q.pop_front();
          check_field("status", want.status, status_i);
          check_field("held_count", want.held, held_count_i);
          check_field("region_valid", want.region_valid, region_valid_i);
          check_field("region_left", want.left, region_left_i);
          check_field("region_top", want.top, region_top_i);
          check_field("region_width", want.width, region_width_i);
          check_field("region_height", want.height, region_height_i);
          check_field("last", want.last, last_i);
        end
      end
    end
    mismatch_count_o <= mismatches;
    pending_words_o  <= region_q.size();
  end

endmodule

@@ tb/dirty_rectangle_tracker_core_tb.sv @@
`timescale 1ns / 1ps

module dirty_rectangle_tracker_core_tb;
  import drt_pkg::*;

  // opcode 3 has no enum member; the block must ignore it
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // cycles without any handshake before the run is declared hung
  localparam int STALL_LIMIT = 1000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // input channel
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       opcode = OP_ADD;
  logic [FIX_W-1:0] rect_left = '0;
  logic [FIX_W-1:0] rect_top = '0;
  logic [FIX_W-1:0] rect_width = '0;
  logic [FIX_W-1:0] rect_height = '0;

  // result channel
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [2:0]       status;
  logic [3:0]       held_count;
  logic             region_valid;
  logic [PIX_W-1:0] region_left;
  logic [PIX_W-1:0] region_top;
  logic [PIX_W-1:0] region_width;
  logic [PIX_W-1:0] region_height;
  logic             last;

  // config channel
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_SURF_W;
  logic [PIX_W-1:0]       cfg_data = '0;

  int mismatch_count;
  int pending_words;
  int idle_cycles = 0;
  logic [7:0] stall_tick = '0;

  // sender burst state
  int burst_left = 0;

  // stimulus shaping: current surface and the last well-formed add
  int surf_w_px = 1920;
  int surf_h_px = 1080;
  int prev_x, prev_y, prev_w, prev_h;
  logic have_prev = 1'b0;

  // surface settings per phase: big, zero, extreme wide, tiny, extreme tall, back to default
  int phase_w[6] = '{16384, 0, 32767, 37, 1, 1920};
  int phase_h[6] = '{16384, 0, 1, 23, 32767, 1080};
  int phase_items[6] = '{80, 30, 60, 90, 50, 80};

  always #2 clk_i = ~clk_i;

  dirty_rectangle_tracker_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .opcode_i       (opcode),
    .rect_left_i    (rect_left),
    .rect_top_i     (rect_top),
    .rect_width_i   (rect_width),
    .rect_height_i  (rect_height),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .held_count_o   (held_count),
    .region_valid_o (region_valid),
    .region_left_o  (region_left),
    .region_top_o   (region_top),
    .region_width_o (region_width),
    .region_height_o(region_height),
    .last_o         (last),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  dirty_rectangle_tracker_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .opcode_i        (opcode),
    .rect_left_i     (rect_left),
    .rect_top_i      (rect_top),
    .rect_width_i    (rect_width),
    .rect_height_i   (rect_height),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .status_i        (status),
    .held_count_i    (held_count),
    .region_valid_i  (region_valid),
    .region_left_i   (region_left),
    .region_top_i    (region_top),
    .region_width_i  (region_width),
    .region_height_i (region_height),
    .last_i          (last),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .mismatch_count_o(mismatch_count),
    .pending_words_o (pending_words)
  );

  // Receiver stall pattern, cycling through four modes of equal length:
  // never stall, random 25%, five eighths of the time, and alternating stall blocks.
  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 8'd1;
    case (stall_tick[7:6])
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 3) == 0);
      2'd2: out_stall <= (stall_tick[2:0] < 3'd5);
      default: out_stall <= stall_tick[4];
    endcase
  end

  // Watchdog: any handshake on any channel resets the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("dirty_rectangle_tracker_core_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Hands one word to the block. Bursts of random length are separated by
  // random gaps; a gap of zero keeps valid high straight into the next burst.
  task automatic send_word(logic [1:0] op, int x, int y, int w, int h);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    opcode      <= op;
    rect_left   <= x[FIX_W-1:0];
    rect_top    <= y[FIX_W-1:0];
    rect_width  <= w[FIX_W-1:0];
    rect_height <= h[FIX_W-1:0];
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // Stops sending and waits for every predicted word to come out. It waits
  // on a clock edge first so the count reflects the word accepted there,
  // then adds slack so the block is truly idle.
  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Writes both surface registers; valid stays high across the two words.
  task automatic set_surface(int w, int h);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_SURF_W;
    cfg_data  <= w[PIX_W-1:0];
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_index <= CFG_SURF_H;
    cfg_data  <= h[PIX_W-1:0];
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    surf_w_px = w;
    surf_h_px = h;
    have_prev = 1'b0;
  endtask

  // Mostly well-formed adds sized to the surface, some placed inside the
  // previous add to hit the covered path, plus mark/clear/unused words and
  // fully random noise.
  task automatic send_random_item();
    int pick, x, y, w, h;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      send_word(OP_MARK, $urandom(), $urandom(), $urandom(), $urandom());
    end else if (pick < 10) begin
      send_word(OP_CLEAR, $urandom(), $urandom(), $urandom(), $urandom());
    end else if (pick < 13) begin
      send_word(OP_UNUSED, $urandom(), $urandom(), $urandom(), $urandom());
    end else if (pick < 22) begin
      send_word(OP_ADD, $urandom(), $urandom(), $urandom(), $urandom());
    end else begin
      if (pick < 40 && have_prev) begin
        x = prev_x + int'($urandom_range(0, 40));
        y = prev_y + int'($urandom_range(0, 40));
        w = prev_w - int'($urandom_range(0, 80));
        h = prev_h - int'($urandom_range(0, 80));
      end else begin
        x = int'($urandom_range(0, (surf_w_px + 4) * 16)) - 40;
        y = int'($urandom_range(0, (surf_h_px + 4) * 16)) - 40;
        w = int'($urandom_range(0, (surf_w_px / 3 + 2) * 16)) - 8;
        h = int'($urandom_range(0, (surf_h_px / 3 + 2) * 16)) - 8;
        prev_x = x;
        prev_y = y;
        prev_w = w;
        prev_h = h;
        have_prev = 1'b1;
      end
      send_word(OP_ADD, x, y, w, h);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, on the reset surface of 1920 x 1080.
    send_word(OP_CLEAR, 0, 0, 0, 0);              // clear on an empty store
    send_word(OP_UNUSED, -1, -1, -1, -1);         // unused opcode, all ones
    send_word(OP_ADD, 0, 0, 0, 0);                // zero size
    // most negative origin, right/bottom end just below zero -> empty
    send_word(OP_ADD, -1048576, -1048576, 1048575, 1048575);
    // most positive origin: floored edge past the surface -> empty
    send_word(OP_ADD, 1048575, 1048575, 1048575, 1048575);
    // fractional edges, top floored below zero and clamped
    send_word(OP_ADD, 21, -7, 161, 33);
    send_word(OP_ADD, 21, -7, 161, 33);           // same again -> covered
    send_word(OP_ADD, 0, 0, 1048575, 1048575);    // clamped to whole surface
    send_word(OP_ADD, 1600, 1600, -16, 32);       // negative width
    send_word(OP_MARK, 0, 0, 0, 0);
    send_word(OP_ADD, 80, 80, 160, 160);          // inside marked surface
    send_word(OP_UNUSED, 0, 0, 0, 0);             // ignored with one held
    send_word(OP_CLEAR, -1, -1, -1, -1);
    // nine disjoint adds: the ninth overflows the store and merges
    for (int i = 0; i < 9; i++)
      send_word(OP_ADD, i * 3200 + 3, i * 1600, 800, 640);
    // right edge ceiled past the surface and clamped
    send_word(OP_ADD, 1900 * 16 + 1, 5, 320, 48);
    send_word(OP_CLEAR, 0, 0, 0, 0);

    repeat (40) send_random_item();

    // Each phase: wait for the block to go idle, resize, mark the whole surface, then random words.
    for (int p = 0; p < 6; p++) begin
      drain_results();
      set_surface(phase_w[p], phase_h[p]);
      send_word(OP_MARK, 0, 0, 0, 0);
      repeat (phase_items[p]) send_random_item();
    end

    drain_results();
    repeat (32) @(posedge clk_i);
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("dirty_rectangle_tracker_core_tb: PASS");
    end else begin
      $display("dirty_rectangle_tracker_core_tb: FAIL");
    end
    $finish;
  end

endmodule
